### rtl/drpi_pkg.sv
// package: shared types, constants and cordic angle table for the pose integrator
package drpi_pkg;

  localparam int CordicSteps = 24;
  localparam int StepW = 5;
  localparam logic signed [34:0] CordicInvGain = 35'sd652032874;
  localparam logic signed [47:0] PosMax = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] PosMin = 48'sh8000_0000_0000;

  // one classified item handed from the front part to the back part
  typedef struct packed {
    logic signed [16:0] speed_sum;
    logic signed [33:0] num;
    logic signed [33:0] den;
    logic               quat_valid;
    logic [19:0]        elapsed_time;
  } drpi_cmd_t;

  // back part sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ATAN,
    ST_DELTA,
    ST_ROT_D,
    ST_VEL,
    ST_ROT_H,
    ST_WORLD,
    ST_SCALE,
    ST_ACC,
    ST_OUT
  } drpi_state_t;

  // arctangent table, 2^32 = full turn
  function automatic logic [31:0] atan_entry(input logic [StepW-1:0] i);
    logic [31:0] r;
    begin
      case (i)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

### rtl/dead_reckoning_pose_integrator_unit.sv
// top level: dead-reckoning pose integrator for a differential-drive vehicle
//
// Input channel: push with full; an item holds wheel speeds, a Q1.15
// orientation quaternion with its valid flag, and elapsed microseconds.
// Result channel: empty with pop; each item gives one result with the
// saturated x/y position in nanometres, the wrapped heading and the body
// velocity. Results appear in item order, exactly one per item.
// From the accepting edge an item passes the operand products and the
// queue, then three 24-step runs of one shared CORDIC unit (yaw atan2,
// cosine and sine of the yaw change, cosine and sine of the heading),
// plus the multiply and accumulate steps. One item is worked on at a
// time; the back part takes no new item until the result of the last
// one has been popped.
// Reset clears position, heading and previous yaw, marks the previous
// yaw valid and empties both queues. While a result waits unpopped the
// back part holds and the front holds at most one further item; full
// stays high until the back part has taken that item.
module dead_reckoning_pose_integrator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_left_speed,
  input  logic signed [15:0] in_right_speed,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_quat_w,
  input  logic               in_quat_valid,
  input  logic [19:0]        in_elapsed_time,
  output logic               empty,
  input  logic               pop,
  output logic signed [47:0] out_x_position,
  output logic signed [47:0] out_y_position,
  output logic [15:0]        out_heading_angle,
  output logic signed [15:0] out_velocity_x,
  output logic signed [15:0] out_velocity_y
);

  drpi_pkg::drpi_cmd_t cmd;
  logic                cmd_valid, cmd_take, res_valid;

  drpi_front u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .left_speed(in_left_speed), .right_speed(in_right_speed),
    .quat_x(in_quat_x), .quat_y(in_quat_y), .quat_z(in_quat_z),
    .quat_w(in_quat_w), .quat_valid(in_quat_valid),
    .elapsed_time(in_elapsed_time),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );

  drpi_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .res_valid(res_valid), .res_take(pop),
    .x_position(out_x_position), .y_position(out_y_position),
    .heading_angle(out_heading_angle),
    .velocity_x(out_velocity_x), .velocity_y(out_velocity_y)
  );

  assign empty = !res_valid;

endmodule

### rtl/drpi_front.sv
// front part: accepts an item, forms the atan2 operands, queues them
module drpi_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic signed [15:0]   left_speed,
  input  logic signed [15:0]   right_speed,
  input  logic signed [15:0]   quat_x,
  input  logic signed [15:0]   quat_y,
  input  logic signed [15:0]   quat_z,
  input  logic signed [15:0]   quat_w,
  input  logic                 quat_valid,
  input  logic [19:0]          elapsed_time,
  output logic                 cmd_valid,
  input  logic                 cmd_take,
  output drpi_pkg::drpi_cmd_t  cmd
);

  // stage one: raw item, products in stage two
  logic                 s1_vld_r, s1_vld_nxt;
  logic signed [15:0]   l_r, r_r, qx_r, qy_r, qz_r, qw_r;
  logic                 qv_r;
  logic [19:0]          dt_r;
  logic signed [31:0]   p_wz_r, p_xy_r, p_yy_r, p_zz_r;
  logic                 s2_vld_r;
  logic signed [16:0]   sum2_r;
  logic                 qv2_r;
  logic [19:0]          dt2_r;
  // two-entry queue to the back part
  drpi_pkg::drpi_cmd_t  q_r [2];
  logic                 wp_r, rp_r;
  logic [1:0]           cnt_r;
  drpi_pkg::drpi_cmd_t  enq;
  logic                 do_enq, do_deq;

  // front holds one item at a time until the back part takes it
  assign full   = s1_vld_r || s2_vld_r || (cnt_r != 2'd0);
  assign s1_vld_nxt = push && !full;

  // operand stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_nxt) begin
      l_r  <= left_speed;
      r_r  <= right_speed;
      qx_r <= quat_x;
      qy_r <= quat_y;
      qz_r <= quat_z;
      qw_r <= quat_w;
      qv_r <= quat_valid;
      dt_r <= elapsed_time;
    end
    p_wz_r <= qw_r * qz_r;
    p_xy_r <= qx_r * qy_r;
    p_yy_r <= qy_r * qy_r;
    p_zz_r <= qz_r * qz_r;
    sum2_r <= 17'(l_r) + 17'(r_r);
    qv2_r  <= qv_r;
    dt2_r  <= dt_r;
  end

  // numerator and denominator of the yaw arctangent
  always_comb begin
    enq.speed_sum    = sum2_r;
    enq.num          = (34'(p_wz_r) + 34'(p_xy_r)) <<< 1;
    enq.den          = (34'sd1 <<< 30) - ((34'(p_yy_r) + 34'(p_zz_r)) <<< 1);
    enq.quat_valid   = qv2_r;
    enq.elapsed_time = dt2_r;
  end

  assign do_enq    = s2_vld_r;
  assign do_deq    = cmd_take && (cnt_r != 2'd0);
  assign cmd_valid = cnt_r != 2'd0;
  assign cmd       = q_r[rp_r];

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_enq) wp_r <= ~wp_r;
      if (do_deq) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_enq} - {1'b0, do_deq};
    end
  end

  always_ff @(posedge clk) begin
    if (do_enq) q_r[wp_r] <= enq;
  end

endmodule

### rtl/drpi_cordic.sv
// shared cordic unit: vectoring for atan2, rotation for cosine and sine
module drpi_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               vec_mode,
  input  logic signed [33:0] in_num,
  input  logic signed [33:0] in_den,
  input  logic [15:0]        in_angle,
  output logic               done,
  output logic [15:0]        angle_out,
  output logic signed [34:0] cos_out,
  output logic signed [34:0] sin_out
);

  logic signed [36:0]             x_r, y_r, x_nxt, y_nxt;
  logic [31:0]                    z_r, z_nxt;
  logic [drpi_pkg::StepW-1:0]     i_r;
  logic                           busy_r, vec_r, flip_r, done_r;
  logic signed [16:0]             rr;
  logic                           dir;
  logic signed [36:0]             dx, dy;
  logic [31:0]                    at;

  assign dx = x_r >>> i_r;
  assign dy = y_r >>> i_r;
  assign at = drpi_pkg::atan_entry(i_r);
  // vectoring drives y to zero, rotation drives z to zero
  assign dir = vec_r ? !y_r[36] : !z_r[31];

  // one micro-rotation
  always_comb begin
    if (vec_r) begin
      x_nxt = dir ? x_r + dy : x_r - dy;
      y_nxt = dir ? y_r - dx : y_r + dx;
      z_nxt = dir ? z_r + at : z_r - at;
    end else begin
      x_nxt = dir ? x_r - dy : x_r + dy;
      y_nxt = dir ? y_r + dx : y_r - dx;
      z_nxt = dir ? z_r - at : z_r + at;
    end
  end

  // argument fold into half circle
  always_comb begin
    rr = 17'(signed'(in_angle));
    if (rr > 17'sd16384) rr = rr - 17'sd32768;
    else if (rr < -17'sd16384) rr = rr + 17'sd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        if (i_r == 5'(drpi_pkg::CordicSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        i_r <= i_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      vec_r <= vec_mode;
      if (vec_mode) begin
        flip_r <= 1'b0;
        if (in_den[33]) begin
          x_r <= -37'(in_den);
          y_r <= -37'(in_num);
          z_r <= 32'h8000_0000;
        end else begin
          x_r <= 37'(in_den);
          y_r <= 37'(in_num);
          z_r <= '0;
        end
      end else begin
        flip_r <= (rr != 17'(signed'(in_angle)));
        x_r    <= 37'(drpi_pkg::CordicInvGain);
        y_r    <= '0;
        z_r    <= 32'(rr) << 16;
      end
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign done      = done_r;
  assign angle_out = 16'((z_r + 32'h8000) >> 16);
  assign cos_out   = flip_r ? -35'(x_r) : 35'(x_r);
  assign sin_out   = flip_r ? -35'(y_r) : 35'(y_r);

endmodule

### rtl/drpi_back.sv
// back part: yaw, body and world velocity, position and heading update
module drpi_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  output logic                 cmd_take,
  input  drpi_pkg::drpi_cmd_t  cmd,
  output logic                 res_valid,
  input  logic                 res_take,
  output logic signed [47:0]   x_position,
  output logic signed [47:0]   y_position,
  output logic [15:0]          heading_angle,
  output logic signed [15:0]   velocity_x,
  output logic signed [15:0]   velocity_y
);

  drpi_pkg::drpi_state_t st_r, st_nxt;
  drpi_pkg::drpi_cmd_t   c_r;
  logic signed [47:0]    xa_r, ya_r;
  logic [15:0]           hd_r, pyaw_r, yaw_r, dl_r, dl_nxt;
  logic                  pvld_r;
  logic signed [15:0]    vx_r, vy_r;
  logic signed [34:0]    cd_r, sd_r;
  logic signed [51:0]    m1_r, m2_r, m3_r, m4_r;
  logic signed [51:0]    wx_r, wy_r;
  logic signed [56:0]    sx_r, sy_r;
  logic                  cstart, cvec, cdone;
  logic [15:0]           cang, aout;
  logic signed [34:0]    cos_w, sin_w;
  logic signed [52:0]    pvx, pvy;
  logic signed [52:0]    rvx, rvy;
  logic signed [35:0]    qx14, qy14;
  logic signed [48:0]    nx, ny;
  logic signed [56:0]    rdx, rdy;
  logic signed [40:0]    ddx, ddy;
  logic                  res_r;
  logic                  go_r;

  drpi_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cstart), .vec_mode(cvec),
    .in_num(c_r.num), .in_den(c_r.den), .in_angle(cang),
    .done(cdone), .angle_out(aout), .cos_out(cos_w), .sin_out(sin_w)
  );

  // yaw change, zero when either yaw is unusable
  assign dl_nxt = (c_r.quat_valid && pvld_r) ? yaw_r - pyaw_r : 16'd0;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      drpi_pkg::ST_IDLE:  if (cmd_valid && !res_r) st_nxt = drpi_pkg::ST_ATAN;
      drpi_pkg::ST_ATAN:  if (cdone) st_nxt = drpi_pkg::ST_DELTA;
      drpi_pkg::ST_DELTA: st_nxt = drpi_pkg::ST_ROT_D;
      drpi_pkg::ST_ROT_D: if (cdone) st_nxt = drpi_pkg::ST_VEL;
      drpi_pkg::ST_VEL:   st_nxt = drpi_pkg::ST_ROT_H;
      drpi_pkg::ST_ROT_H: if (cdone) st_nxt = drpi_pkg::ST_WORLD;
      drpi_pkg::ST_WORLD: st_nxt = drpi_pkg::ST_SCALE;
      drpi_pkg::ST_SCALE: st_nxt = drpi_pkg::ST_ACC;
      drpi_pkg::ST_ACC:   st_nxt = drpi_pkg::ST_OUT;
      drpi_pkg::ST_OUT:   st_nxt = drpi_pkg::ST_IDLE;
      default:            st_nxt = drpi_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_take = 1'b0;
    cstart   = 1'b0;
    cvec     = 1'b0;
    cang     = dl_r;
    unique case (st_r)
      drpi_pkg::ST_IDLE:  cmd_take = cmd_valid && !res_r;
      drpi_pkg::ST_ATAN: begin
        cstart = go_r;
        cvec   = 1'b1;
      end
      drpi_pkg::ST_DELTA: begin
        cstart = 1'b1;
        cang   = dl_nxt;
      end
      drpi_pkg::ST_ROT_D: ;
      drpi_pkg::ST_VEL: begin
        cstart = 1'b1;
        cang   = hd_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= drpi_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  // the vectoring run starts in the cycle after the command is taken, once it is latched
  always_ff @(posedge clk) begin
    if (!rst_n) go_r <= 1'b0;
    else        go_r <= cmd_take;
  end

  // body velocity and world rotation arithmetic
  assign pvx  = 53'(signed'(c_r.speed_sum >>> 1)) * 53'(cd_r);
  assign pvy  = 53'(signed'(c_r.speed_sum >>> 1)) * 53'(sd_r);
  assign rvx  = (pvx + (53'sd1 <<< 29)) >>> 30;
  assign rvy  = (pvy + (53'sd1 <<< 29)) >>> 30;
  assign qx14 = 36'((wx_r + (52'sd1 <<< 15)) >>> 16);
  assign qy14 = 36'((wy_r + (52'sd1 <<< 15)) >>> 16);
  assign rdx  = (sx_r + (57'sd1 <<< 13)) >>> 14;
  assign rdy  = (sy_r + (57'sd1 <<< 13)) >>> 14;
  assign ddx  = 41'(rdx);
  assign ddy  = 41'(rdy);
  assign nx   = 49'(xa_r) + 49'(ddx);
  assign ny   = 49'(ya_r) + 49'(ddy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xa_r   <= '0;
      ya_r   <= '0;
      hd_r   <= '0;
      pyaw_r <= '0;
      pvld_r <= 1'b1;
      res_r  <= 1'b0;
    end else begin
      if (st_r == drpi_pkg::ST_ACC) begin
        xa_r   <= (nx > 49'(drpi_pkg::PosMax)) ? drpi_pkg::PosMax :
                  (nx < 49'(drpi_pkg::PosMin)) ? drpi_pkg::PosMin : 48'(nx);
        ya_r   <= (ny > 49'(drpi_pkg::PosMax)) ? drpi_pkg::PosMax :
                  (ny < 49'(drpi_pkg::PosMin)) ? drpi_pkg::PosMin : 48'(ny);
        hd_r   <= hd_r + dl_r;
        pyaw_r <= yaw_r;
        pvld_r <= c_r.quat_valid;
      end
      if (st_r == drpi_pkg::ST_OUT) res_r <= 1'b1;
      else if (res_take) res_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) c_r <= cmd;
    if (st_r == drpi_pkg::ST_ATAN && cdone) yaw_r <= aout;
    if (st_r == drpi_pkg::ST_DELTA) dl_r <= dl_nxt;
    if (st_r == drpi_pkg::ST_ROT_D && cdone) begin
      cd_r <= cos_w;
      sd_r <= sin_w;
    end
    if (st_r == drpi_pkg::ST_VEL) begin
      vx_r <= (rvx > 53'sd32767) ? 16'sh7FFF : (rvx < -53'sd32768) ? 16'sh8000 : 16'(rvx);
      vy_r <= (rvy > 53'sd32767) ? 16'sh7FFF : (rvy < -53'sd32768) ? 16'sh8000 : 16'(rvy);
    end
    if (st_r == drpi_pkg::ST_ROT_H && cdone) begin
      m1_r <= 52'(vx_r * cos_w);
      m2_r <= 52'(vy_r * sin_w);
      m3_r <= 52'(vx_r * sin_w);
      m4_r <= 52'(vy_r * cos_w);
    end
    if (st_r == drpi_pkg::ST_WORLD) begin
      wx_r <= m1_r - m2_r;
      wy_r <= m3_r + m4_r;
    end
    if (st_r == drpi_pkg::ST_SCALE) begin
      sx_r <= 57'(qx14) * 57'(signed'({1'b0, c_r.elapsed_time}));
      sy_r <= 57'(qy14) * 57'(signed'({1'b0, c_r.elapsed_time}));
    end
  end

  assign res_valid     = res_r;
  assign x_position    = xa_r;
  assign y_position    = ya_r;
  assign heading_angle = hd_r;
  assign velocity_x    = vx_r;
  assign velocity_y    = vy_r;

endmodule

### rtl/drpi_checker.sv
// checker: port-level properties of the pose integrator, bound to the top level
module drpi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [15:0] out_heading_angle,
  input logic [15:0] out_velocity_x
);

  // nothing waits right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result present after reset");

  // an accepted item is never answered in the next cycle
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && empty) |=> empty)
    else $error("result too early");

  // a waiting result holds its heading and x velocity until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_heading_angle)
                          && $stable(out_velocity_x)))
    else $error("waiting result changed");

  // a popped result does not reappear at once
  a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && pop) |=> empty)
    else $error("result repeated");

endmodule

bind dead_reckoning_pose_integrator_unit drpi_checker u_drpi_checker (
  .clk(clk), .rst_n(rst_n), .push(push), .full(full), .empty(empty),
  .pop(pop), .out_heading_angle(out_heading_angle),
  .out_velocity_x(out_velocity_x)
);
